// ===== design/gf2bsc_pkg.sv =====
// Package for the GF(2) basis span coordinate block.
// Holds the beat structs and the action and status codes; no dependencies.
package gf2bsc_pkg;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_I2E  = 2'd2;
	localparam logic [1:0] ACT_E2I  = 2'd3;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_FULL  = 3'd1;
	localparam logic [2:0] ST_EMPTY = 3'd2;
	localparam logic [2:0] ST_RANGE = 3'd3;
	localparam logic [2:0] ST_DEP   = 3'd4;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] element_in;
		logic [31:0] index_in;
	} cmd_t;

	typedef struct packed {
		logic [63:0] element_out;
		logic [31:0] index_out;
		logic        in_span;
		logic [2:0]  status;
		logic [5:0]  basis_size;
	} rsp_t;

endpackage

// ===== design/gf2bsc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module gf2bsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/gf2_basis_span_coordinates_top.sv =====
// Top level of the GF(2) basis span coordinate block.
// Uses gf2bsc_pkg (beat structs, codes) and gf2bsc_ram (basis and pivot rows).
//
// Usage: pulse start with a command beat while busy is low. The block goes
// busy and later drives one result beat on rsp for one cycle with done high;
// the receiver cannot stall it. field_degree is written on the cfg_valid /
// cfg_ready channel while idle; cfg_ready is high whenever busy is low.
// Push and pop go straight to the done state. Index to element reads the
// basis RAM once per held vector. Element to index runs the elimination on
// one shared XOR/AND row unit: vector i takes a RAM read, a load and a
// store step, plus a read and then a reduce for each earlier pivot row,
// and the element takes a read and a reduce per pivot row plus a store step.
// Each pivot row is read from the registered RAM before it is reduced.
// The block takes no new beat until the last one is done; busy stays high
// until the done cycle.
// Reset clears the vector count and sets field_degree to 64; RAM contents
// are undefined until pushed.
module gf2_basis_span_coordinates_top #(
	parameter int MAX_BASIS  = 32,
	parameter int FIELD_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  gf2bsc_pkg::cmd_t   cmd,
	output logic               done,
	output gf2bsc_pkg::rsp_t   rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data
);
	localparam int AW = 5;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_I2E   = 4'd1;
	localparam logic [3:0] S_I2EW  = 4'd2;
	localparam logic [3:0] S_LOADV = 4'd3;
	localparam logic [3:0] S_LOADW = 4'd4;
	localparam logic [3:0] S_RED   = 4'd5;
	localparam logic [3:0] S_REDW  = 4'd6;
	localparam logic [3:0] S_STORE = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]  state_q;
	logic [5:0]  count_q;
	logic [6:0]  deg_q;
	gf2bsc_pkg::cmd_t cmd_q;
	logic [63:0] mask;
	logic [63:0] acc_q;
	logic [31:0] comb_q;
	logic [5:0]  i_q, k_q, rows_q;
	logic        dep_q, final_q;
	gf2bsc_pkg::rsp_t rsp_q;
	logic        done_q;

	logic        bwe;
	logic [AW-1:0] bwaddr, braddr;
	logic [63:0] brdata;
	logic        rwe;
	logic [AW-1:0] rraddr;
	logic [95:0] rrdata, rwdata;
	logic [63:0] piv_r;

	always_comb begin
		logic [6:0] d;
		d = deg_q;
		if (d < 7'd1) d = 7'd1;
		if (d > 7'(FIELD_BITS)) d = 7'(FIELD_BITS);
		if (d >= 7'd64) mask = '1;
		else mask = (64'd1 << d[5:0]) - 64'd1;
	end

	gf2bsc_ram #(.WIDTH(64), .DEPTH(32)) u_basis (
		.clk(clk), .we(bwe), .waddr(bwaddr), .wdata(cmd.element_in),
		.raddr(braddr), .rdata(brdata)
	);
	// pivot rows: {comb, row}
	gf2bsc_ram #(.WIDTH(96), .DEPTH(32)) u_rows (
		.clk(clk), .we(rwe), .waddr(rows_q[AW-1:0]), .wdata(rwdata),
		.raddr(rraddr), .rdata(rrdata)
	);

	assign piv_r  = rrdata[63:0] & (~rrdata[63:0] + 64'd1);
	assign bwe    = start && !busy && cmd.action == gf2bsc_pkg::ACT_PUSH
		&& count_q < 6'(MAX_BASIS);
	assign bwaddr = count_q[AW-1:0];
	assign braddr = i_q[AW-1:0];
	assign rraddr = k_q[AW-1:0];
	assign rwe    = state_q == S_STORE && !final_q && acc_q != 64'd0;
	assign rwdata = {comb_q, acc_q};

	assign busy      = state_q != S_IDLE;
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			deg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						rsp_q <= '0;
						acc_q <= '0;
						comb_q <= '0;
						i_q <= '0;
						k_q <= '0;
						rows_q <= '0;
						dep_q <= 1'b0;
						final_q <= 1'b0;
						case (cmd.action)
							gf2bsc_pkg::ACT_PUSH: begin
								if (count_q >= 6'(MAX_BASIS)) begin
									rsp_q.status <= gf2bsc_pkg::ST_FULL;
									rsp_q.basis_size <= count_q;
								end else begin
									count_q <= count_q + 6'd1;
									rsp_q.basis_size <= count_q + 6'd1;
								end
								state_q <= S_DONE;
							end
							gf2bsc_pkg::ACT_POP: begin
								if (count_q == 6'd0) begin
									rsp_q.status <= gf2bsc_pkg::ST_EMPTY;
									rsp_q.basis_size <= count_q;
								end else begin
									count_q <= count_q - 6'd1;
									rsp_q.basis_size <= count_q - 6'd1;
								end
								state_q <= S_DONE;
							end
							gf2bsc_pkg::ACT_I2E: begin
								rsp_q.basis_size <= count_q;
								if (count_q < 6'd32 &&
									(cmd.index_in >> count_q) != 32'd0) begin
									rsp_q.status <= gf2bsc_pkg::ST_RANGE;
									state_q <= S_DONE;
								end else if (count_q == 6'd0) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_I2EW;
								end
							end
							default: begin
								rsp_q.basis_size <= count_q;
								if (count_q == 6'd0) begin
									final_q <= 1'b1;
									acc_q <= cmd.element_in & mask;
									state_q <= S_STORE;
								end else begin
									state_q <= S_LOADW;
								end
							end
						endcase
					end
				end
				S_I2EW: begin
					state_q <= S_I2E;
					i_q <= i_q + 6'd1;
				end
				S_I2E: begin
					if (cmd_q.index_in[i_q[AW-1:0] - 5'd1])
						rsp_q.element_out <= rsp_q.element_out ^ (brdata & mask);
					if (i_q == count_q) state_q <= S_DONE;
					else i_q <= i_q + 6'd1;
				end
				S_LOADW: state_q <= S_LOADV;
				S_LOADV: begin
					acc_q <= brdata & mask;
					comb_q <= 32'd1 << i_q[AW-1:0];
					k_q <= '0;
					state_q <= rows_q == 6'd0 ? S_STORE : S_REDW;
				end
				S_REDW: state_q <= S_RED;
				S_RED: begin
					if ((acc_q & piv_r) != 64'd0) begin
						acc_q <= acc_q ^ rrdata[63:0];
						comb_q <= comb_q ^ rrdata[95:64];
					end
					if (k_q + 6'd1 == rows_q) state_q <= S_STORE;
					else begin
						k_q <= k_q + 6'd1;
						state_q <= S_REDW;
					end
				end
				S_STORE: begin
					if (final_q) begin
						if (acc_q == 64'd0) begin
							rsp_q.in_span <= 1'b1;
							rsp_q.index_out <= dep_q ? 32'd0 : comb_q;
						end
						if (dep_q) rsp_q.status <= gf2bsc_pkg::ST_DEP;
						state_q <= S_DONE;
					end else begin
						if (acc_q == 64'd0) dep_q <= 1'b1;
						rows_q <= rows_q + 6'(acc_q != 64'd0);
						if (i_q + 6'd1 == count_q) begin
							final_q <= 1'b1;
							acc_q <= cmd_q.element_in & mask;
							comb_q <= '0;
							k_q <= '0;
							if (rows_q + 6'(acc_q != 64'd0) == 6'd0) state_q <= S_STORE;
							else state_q <= S_REDW;
						end else begin
							i_q <= i_q + 6'd1;
							state_q <= S_LOADW;
						end
					end
				end
				default: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 6'(MAX_BASIS)) else $error("count overflow");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
endmodule
